/* rtl/lr_pkg.sv */
// shared types, constants and helpers for the line rasterizer
package lr_pkg;

  // coordinate width and error term width
  localparam int COORD_BITS = 9;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 16;

  // apb register map
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam logic [1:0] REG_LANDSCAPE   = 2'd0;
  localparam logic [1:0] REG_PANEL_MAX_Y = 2'd1;
  localparam logic [1:0] REG_DRAW_COLOR  = 2'd2;

  // register reset values
  localparam logic [COORD_BITS-1:0] PANEL_MAX_Y_RESET = COORD_BITS'(479);
  localparam logic [COLOR_BITS-1:0] DRAW_COLOR_RESET  = 16'hFFFF;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // input item
  typedef struct packed {
    logic   operation;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } lr_in_t;

  // result item
  typedef struct packed {
    logic                  valid_res;
    coord_t                addr_col;
    coord_t                addr_row;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } lr_out_t;

  // classified command from front to back
  typedef struct packed {
    logic   is_start;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t span_x;
    coord_t span_y;
    logic   col_dir_neg;
    logic   row_dir_neg;
    logic   steep;
    err_t   err_init;
  } lr_cmd_t;

  // configuration seen by the walker
  typedef struct packed {
    logic                  landscape;
    coord_t                panel_max_y;
    logic [COLOR_BITS-1:0] draw_color;
  } lr_cfg_t;

  // move a coordinate one step, wrapping at the coordinate width
  function automatic coord_t coord_move(input coord_t v, input logic neg);
    coord_move = neg ? (v - coord_t'(1)) : (v + coord_t'(1));
  endfunction

endpackage

/* rtl/line_rasterizer_core.sv */
// line rasterizer top level: config registers, front end, queue and walker
// an accepted item is held in the queue, and its result is registered when the walker takes it
// throughput: one item per cycle, unless the output stalls and the queue fills up
// the two-entry queue lets the input side run on while the output stalls
// reset: synchronous, clears queue, walker activity and output valid
// reset also loads landscape 0, panel_max_y 479 and draw_color 65535
module line_rasterizer_core import lr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lr_in_t               in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lr_out_t              out_item,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  lr_cfg_t cfg;
  lr_cmd_t front_cmd;
  lr_cmd_t q_cmd;
  logic    q_valid;
  logic    q_stall;
  logic    cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.landscape   <= 1'b0;
      cfg.panel_max_y <= PANEL_MAX_Y_RESET;
      cfg.draw_color  <= DRAW_COLOR_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_LANDSCAPE:   cfg.landscape   <= pwdata[0];
        REG_PANEL_MAX_Y: cfg.panel_max_y <= pwdata[COORD_BITS-1:0];
        REG_DRAW_COLOR:  cfg.draw_color  <= pwdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_LANDSCAPE:   prdata = {{(DATA_BITS-1){1'b0}}, cfg.landscape};
      REG_PANEL_MAX_Y: prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, cfg.panel_max_y};
      REG_DRAW_COLOR:  prdata = {{(DATA_BITS-COLOR_BITS){1'b0}}, cfg.draw_color};
      default:         prdata = '0;
    endcase
  end

  lr_front u_front (
    .in_item (in_item),
    .cmd     (front_cmd)
  );

  lr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (front_cmd),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_data   (q_cmd)
  );

  lr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_stall (q_stall),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* rtl/lr_front.sv */
// front end: decodes input items and precomputes line setup
module lr_front import lr_pkg::*; (
  input  lr_in_t  in_item,
  output lr_cmd_t cmd
);

  coord_t span_x;
  coord_t span_y;
  coord_t major;
  logic   col_neg;
  logic   row_neg;
  logic   steep;

  // direction and span per axis
  always_comb begin
    col_neg = in_item.end_x < in_item.start_x;
    row_neg = in_item.end_y < in_item.start_y;
    span_x  = col_neg ? (in_item.start_x - in_item.end_x) : (in_item.end_x - in_item.start_x);
    span_y  = row_neg ? (in_item.start_y - in_item.end_y) : (in_item.end_y - in_item.start_y);
    steep   = span_x < span_y;
    major   = steep ? span_y : span_x;
  end

  // build the command
  always_comb begin
    cmd.is_start    = (in_item.operation == OP_START);
    cmd.x1          = in_item.start_x;
    cmd.y1          = in_item.start_y;
    cmd.x2          = in_item.end_x;
    cmd.y2          = in_item.end_y;
    cmd.span_x      = span_x;
    cmd.span_y      = span_y;
    cmd.col_dir_neg = col_neg;
    cmd.row_dir_neg = row_neg;
    cmd.steep       = steep;
    cmd.err_init    = err_t'(0) - $signed({3'b000, major[COORD_BITS-1:1]});
  end

endmodule

/* rtl/lr_queue.sv */
// two-entry command queue between front and back
module lr_queue import lr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_stall,
  input  lr_cmd_t push_data,
  output logic    pop_valid,
  input  logic    pop_stall,
  output lr_cmd_t pop_data
);

  lr_cmd_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

/* rtl/lr_back.sv */
// back end: bresenham walker with registered result item
module lr_back import lr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  lr_cfg_t cfg,
  input  logic    cmd_valid,
  output logic    cmd_stall,
  input  lr_cmd_t cmd,
  output logic    out_valid,
  input  logic    out_stall,
  output lr_out_t out_item
);

  // walker state
  coord_t cur_col, cur_col_next;
  coord_t cur_row, cur_row_next;
  coord_t goal_col, goal_col_next;
  coord_t goal_row, goal_row_next;
  coord_t span_x, span_x_next;
  coord_t span_y, span_y_next;
  err_t   err, err_next;
  logic   col_neg, col_neg_next;
  logic   row_neg, row_neg_next;
  logic   steep, steep_next;
  logic   active, active_next;

  lr_out_t res;
  err_t    err_add;
  logic    fin;
  logic    take;

  assign cmd_stall = out_valid && out_stall;
  assign take      = cmd_valid && !cmd_stall;

  // next walker state
  always_comb begin
    cur_col_next  = cur_col;
    cur_row_next  = cur_row;
    goal_col_next = goal_col;
    goal_row_next = goal_row;
    span_x_next   = span_x;
    span_y_next   = span_y;
    err_next      = err;
    col_neg_next  = col_neg;
    row_neg_next  = row_neg;
    steep_next    = steep;
    err_add       = err + $signed({2'b00, (steep ? span_x : span_y)});
    if (cmd.is_start) begin
      cur_col_next  = cmd.x1;
      cur_row_next  = cmd.y1;
      goal_col_next = cmd.x2;
      goal_row_next = cmd.y2;
      span_x_next   = cmd.span_x;
      span_y_next   = cmd.span_y;
      err_next      = cmd.err_init;
      col_neg_next  = cmd.col_dir_neg;
      row_neg_next  = cmd.row_dir_neg;
      steep_next    = cmd.steep;
    end else if (active) begin
      err_next = err_add;
      if (steep) begin
        cur_row_next = coord_move(cur_row, row_neg);
        if (!err_add[ERR_BITS-1]) begin
          cur_col_next = coord_move(cur_col, col_neg);
          err_next     = err_add - $signed({2'b00, span_y});
        end
      end else begin
        cur_col_next = coord_move(cur_col, col_neg);
        if (!err_add[ERR_BITS-1]) begin
          cur_row_next = coord_move(cur_row, row_neg);
          err_next     = err_add - $signed({2'b00, span_x});
        end
      end
    end
  end

  // pixel emission and orientation transform
  always_comb begin
    fin = steep_next ? (cur_row_next == goal_row_next) : (cur_col_next == goal_col_next);
    res = '0;
    active_next = active;
    if (cmd.is_start || active) begin
      res.valid_res   = 1'b1;
      res.pixel_color = cfg.draw_color;
      res.last        = fin;
      active_next     = !fin;
      if (cfg.landscape) begin
        res.addr_col = cur_row_next;
        res.addr_row = cfg.panel_max_y - cur_col_next;
      end else begin
        res.addr_col = cur_col_next;
        res.addr_row = cur_row_next;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) active <= active_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walker payload and result register
  always_ff @(posedge clk) begin
    if (take) begin
      cur_col  <= cur_col_next;
      cur_row  <= cur_row_next;
      goal_col <= goal_col_next;
      goal_row <= goal_row_next;
      span_x   <= span_x_next;
      span_y   <= span_y_next;
      err      <= err_next;
      col_neg  <= col_neg_next;
      row_neg  <= row_neg_next;
      steep    <= steep_next;
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  // a delivered end point leaves no line in progress
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.valid_res && out_item.last |-> !active)
    else $error("line still active after last pixel");

  // a step with no line in progress yields an empty result
  assert property (@(posedge clk) disable iff (rst)
    take && !cmd.is_start && !active |=> out_valid && !out_item.valid_res)
    else $error("idle step produced a pixel");

  // an active line has not yet reached its major end
  assert property (@(posedge clk) disable iff (rst)
    active |-> (steep ? (cur_row != goal_row) : (cur_col != goal_col)))
    else $error("active line already at its end point");
`endif

endmodule

/* tb/sv/line_rasterizer_core_test.sv */
// testbench for the line rasterizer core: directed and random line walks
module line_rasterizer_core_test;
  import lr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 150;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 4;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  lr_in_t               in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  lr_out_t              out_item;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  line_rasterizer_core i_dut (
    .clk, .rst, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk = ~clk;

  // predicted panel setup
  logic                  orient_land = 1'b0;
  coord_t                mirror_max  = PANEL_MAX_Y_RESET;
  logic [COLOR_BITS-1:0] ink         = DRAW_COLOR_RESET;

  // predicted walker state
  coord_t pen_col = '0, pen_row = '0, tgt_col = '0, tgt_row = '0;
  coord_t run_x = '0, run_y = '0;
  int     walk_err = 0;
  logic   x_back = 1'b0, y_back = 1'b0, y_major = 1'b0, drawing = 1'b0;

  lr_out_t expected_pixels[$];
  int      fail_count = 0;
  bit      quiet = 1'b0;
  int      hold_ask = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      stuck_cycles = 0;

  // advance the predicted walker by one item and queue the pixel it gives
  task automatic walk_pixel(input lr_in_t it);
    lr_out_t px;
    coord_t  major;
    px = '0;
    if (it.operation == OP_START || drawing) begin
      if (it.operation == OP_START) begin
        x_back  = it.end_x < it.start_x;
        y_back  = it.end_y < it.start_y;
        run_x   = x_back ? it.start_x - it.end_x : it.end_x - it.start_x;
        run_y   = y_back ? it.start_y - it.end_y : it.end_y - it.start_y;
        y_major = run_x < run_y;
        major   = y_major ? run_y : run_x;
        walk_err = -int'(major >> 1);
        pen_col = it.start_x;
        pen_row = it.start_y;
        tgt_col = it.end_x;
        tgt_row = it.end_y;
      end else if (y_major) begin
        pen_row = y_back ? pen_row - 1'b1 : pen_row + 1'b1;
        walk_err += int'(run_x);
        if (walk_err >= 0) begin
          pen_col = x_back ? pen_col - 1'b1 : pen_col + 1'b1;
          walk_err -= int'(run_y);
        end
      end else begin
        pen_col = x_back ? pen_col - 1'b1 : pen_col + 1'b1;
        walk_err += int'(run_y);
        if (walk_err >= 0) begin
          pen_row = y_back ? pen_row - 1'b1 : pen_row + 1'b1;
          walk_err -= int'(run_x);
        end
      end
      px.valid_res   = 1'b1;
      px.addr_col    = orient_land ? pen_row : pen_col;
      px.addr_row    = orient_land ? coord_t'(mirror_max - pen_col) : pen_row;
      px.pixel_color = ink;
      px.last        = y_major ? (pen_row == tgt_row) : (pen_col == tgt_col);
      drawing        = !px.last;
    end
    expected_pixels.push_back(px);
  endtask

  // offer one item, idling at random beforehand, and predict it once taken
  task automatic offer_item(input lr_in_t it);
    while (!quiet && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    walk_pixel(it);
  endtask

  // step item with random content in the unused endpoint fields
  function automatic lr_in_t step_cmd();
    lr_in_t it;
    it.operation = OP_STEP;
    it.start_x   = coord_t'($urandom_range(511));
    it.start_y   = coord_t'($urandom_range(511));
    it.end_x     = coord_t'($urandom_range(511));
    it.end_y     = coord_t'($urandom_range(511));
    return it;
  endfunction

  // start item followed by a number of step items
  task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                           input int steps);
    lr_in_t it;
    it.operation = OP_START;
    it.start_x   = coord_t'(x1);
    it.start_y   = coord_t'(y1);
    it.end_x     = coord_t'(x2);
    it.end_y     = coord_t'(y2);
    offer_item(it);
    repeat (steps) offer_item(step_cmd());
  endtask

  // stop offering and wait until every pixel has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup then access phase
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    unique case (idx)
      REG_LANDSCAPE:   orient_land = val[0];
      REG_PANEL_MAX_Y: mirror_max  = coord_t'(val);
      REG_DRAW_COLOR:  ink         = val[COLOR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_panel(input logic land, input int max_y, input int color);
    settle();
    write_reg(REG_LANDSCAPE, DATA_BITS'(land));
    write_reg(REG_PANEL_MAX_Y, DATA_BITS'(max_y));
    write_reg(REG_DRAW_COLOR, DATA_BITS'(color));
  endtask

  // steps with no line, then a single point line, under the reset setup
  task automatic test_reset_setup();
    lr_in_t it;
    it = '1;
    offer_item(it);
    offer_item(step_cmd());
    draw_line(0, 0, 0, 0, 1);
  endtask

  // horizontal line walked to the end and one past it, vertical line walked to its end
  task automatic test_axis_lines();
    draw_line(3, 7, 7, 7, 5);
    draw_line(10, 9, 10, 6, 3);
  endtask

  // corner to corner lines, each cut short by the next start, then a partial line from the origin
  task automatic test_corner_lines();
    draw_line(511, 511, 0, 0, 2);
    draw_line(0, 511, 511, 0, 2);
    draw_line(0, 0, 511, 200, 1);
  endtask

  // landscape swap, mirror wrap below zero, register extremes
  task automatic test_landscape();
    set_panel(1'b1, 0, 0);
    draw_line(5, 3, 8, 10, 7);
    set_panel(1'b1, 511, 16'hA5A5);
    draw_line(511, 0, 500, 2, 2);
  endtask

  // output held off while items keep coming, then a full drain
  task automatic test_back_pressure();
    set_panel(1'b0, 479, 16'h1234);
    hold_ask++;
    draw_line(20, 30, 60, 45, 40);
    settle();
    draw_line(100, 100, 90, 130, 30);
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > 511) ? 511 : v);
  endfunction

  // random lines, mostly well formed, some cut short or overrun, some noise
  task automatic random_lines(input int n_items);
    lr_in_t it;
    int     sent, roll, dx, dy, major, steps;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        it = step_cmd();
        it.operation = logic'($urandom_range(1));
        offer_item(it);
        sent++;
      end else begin
        it.operation = OP_START;
        it.start_x   = coord_t'($urandom_range(511));
        it.start_y   = coord_t'($urandom_range(511));
        if (roll < 20) begin
          it.end_x = coord_t'($urandom_range(511));
          it.end_y = coord_t'($urandom_range(511));
        end else begin
          it.end_x = coord_t'(clamp_coord(int'(it.start_x) + int'($urandom_range(48)) - 24));
          it.end_y = coord_t'(clamp_coord(int'(it.start_y) + int'($urandom_range(48)) - 24));
        end
        offer_item(it);
        sent++;
        dx = int'(it.end_x) - int'(it.start_x);
        dy = int'(it.end_y) - int'(it.start_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        major = (dx > dy) ? dx : dy;
        roll  = $urandom_range(99);
        if (roll < 15) steps = $urandom_range(major);
        else if (roll < 30) steps = major + $urandom_range(3, 1);
        else steps = major;
        if (steps > 40) steps = 40;
        repeat (steps) offer_item(step_cmd());
        sent += steps;
      end
    end
  endtask

  task automatic test_random_phases();
    set_panel(1'b0, 479, $urandom_range(65535));
    random_lines(130);
    set_panel(1'b1, 511, 0);
    quiet = 1'b1;
    random_lines(130);
    quiet = 1'b0;
    set_panel(1'b1, $urandom_range(511), $urandom_range(65535));
    random_lines(130);
    set_panel(1'b0, 0, 65535);
    random_lines(120);
  endtask

  // output side: random stalls, quiet stretches, counted hold-off
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 19);
    end
  end

  // compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin : check_pixels
    lr_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected pixel: valid %0b col %0d row %0d color %h last %0b",
                   out_item.valid_res, out_item.addr_col, out_item.addr_row,
                   out_item.pixel_color, out_item.last);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_item.valid_res !== want.valid_res || out_item.addr_col !== want.addr_col ||
            out_item.addr_row !== want.addr_row ||
            out_item.pixel_color !== want.pixel_color || out_item.last !== want.last) begin
          if (fail_count < 10)
            $display("mismatch: want v%0b c%0d r%0d k%h l%0b, got v%0b c%0d r%0d k%h l%0b",
                     want.valid_res, want.addr_col, want.addr_row, want.pixel_color,
                     want.last, out_item.valid_res, out_item.addr_col, out_item.addr_row,
                     out_item.pixel_color, out_item.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_setup();
    test_axis_lines();
    test_corner_lines();
    test_landscape();
    test_back_pressure();
    test_random_phases();
    settle();
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lr_pkg.sv
rtl/lr_front.sv
rtl/lr_queue.sv
rtl/lr_back.sv
rtl/line_rasterizer_core.sv
tb/sv/line_rasterizer_core_test.sv
